FILE: rtl/core/pcpf_pkg.sv
// Shared constants and controller/datapath interface types for the profile corner point finder.
package pcpf_pkg;

  localparam int DefMaxPoints = 1024;
  localparam int DefCoordBits = 12;

  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 8;
  localparam int ShiftW   = 8;

  localparam logic [CfgIdxW-1:0] CfgIdxDirection = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxShift     = 8'd1;

  localparam logic [ShiftW-1:0] ShiftReset = 8'd15;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // a point request is accepted this cycle
    logic issue;   // read the next stored point for the scan
    logic commit;  // write the result register and clear the contour
  } pcpf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic issue_done;  // every stored point has been read
    logic pipe_busy;   // scan pipeline still holds points
    logic out_free;    // result register can take a new result
  } pcpf_sts_t;

endpackage

FILE: rtl/core/pcpf_ctrl.sv
// Controller state machine: load phase, scan over stored points, result hand-off.
module pcpf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_last_i,
  output logic                in_ready_o,
  input  pcpf_pkg::pcpf_sts_t sts_i,
  output pcpf_pkg::pcpf_cmd_t cmd_o
);

  localparam logic [1:0] StLoad = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == StLoad);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d      = state_q;
    cmd_o.load   = 1'b0;
    cmd_o.issue  = 1'b0;
    cmd_o.commit = 1'b0;
    case (state_q)
      StLoad: begin
        cmd_o.load = accept;
        if (accept && in_last_i) begin
          state_d = StScan;
        end
      end
      StScan: begin
        cmd_o.issue = !sts_i.issue_done;
        if (sts_i.issue_done && !sts_i.pipe_busy) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = StLoad;
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/core/pcpf_datapath.sv
// Datapath: configuration registers, point store, extreme tracking, scan pipeline, result register.
module pcpf_datapath #(
  parameter int MaxPoints = pcpf_pkg::DefMaxPoints,
  parameter int CoordBits = pcpf_pkg::DefCoordBits
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pcpf_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [pcpf_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic [CoordBits-1:0]             in_x_i,
  input  logic [CoordBits-1:0]             in_y_i,
  input  pcpf_pkg::pcpf_cmd_t              cmd_i,
  output pcpf_pkg::pcpf_sts_t              sts_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [CoordBits-1:0]             top_x_o,
  output logic [CoordBits-1:0]             top_y_o,
  output logic [CoordBits-1:0]             side_x_o,
  output logic [CoordBits-1:0]             side_y_o,
  output logic                             side_found_o
);

  localparam int AW = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  localparam int CW = $clog2(MaxPoints + 1);
  localparam int SW = CoordBits + AW;
  localparam int PW = CoordBits + CW;
  localparam int XW = CoordBits + 2;
  localparam int DW = CoordBits + 1;
  localparam int EW = 2 * CoordBits;

  // Configuration.
  logic                        dir_q;
  logic [pcpf_pkg::ShiftW-1:0] shift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q   <= 1'b0;
      shift_q <= pcpf_pkg::ShiftReset;
    end else if (cfg_we_i) begin
      if (cfg_index_i == pcpf_pkg::CfgIdxDirection) begin
        dir_q <= cfg_data_i[0];
      end else if (cfg_index_i == pcpf_pkg::CfgIdxShift) begin
        shift_q <= cfg_data_i[pcpf_pkg::ShiftW-1:0];
      end
    end
  end

  // Contour state kept while loading.
  logic [CW-1:0]        count_q;
  logic [CoordBits-1:0] ext_x_q;
  logic [CoordBits-1:0] top_y_q;
  logic [SW-1:0]        sum_q;
  logic                 store_en;
  logic                 better;

  assign store_en = cmd_i.load && (count_q < CW'(MaxPoints));
  assign better   = (count_q == '0) || (dir_q ? (in_x_i > ext_x_q) : (in_x_i < ext_x_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ext_x_q <= '0;
      sum_q   <= '0;
    end else if (cmd_i.commit) begin
      count_q <= '0;
      ext_x_q <= '0;
      sum_q   <= '0;
    end else if (store_en) begin
      count_q <= count_q + CW'(1);
      sum_q   <= sum_q + SW'(in_y_i);
      if (better) begin
        ext_x_q <= in_x_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_en && better) begin
      top_y_q <= in_y_i;
    end
  end

  // Point store, x in the low half and y above.
  logic [EW-1:0] mem_q [MaxPoints];
  logic [EW-1:0] rd_q;
  logic [CW-1:0] scan_q;

  always_ff @(posedge clk_i) begin
    if (store_en) begin
      mem_q[count_q[AW-1:0]] <= {in_y_i, in_x_i};
    end
    if (cmd_i.issue) begin
      rd_q <= mem_q[scan_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
    end else if (cmd_i.commit) begin
      scan_q <= '0;
    end else if (cmd_i.issue) begin
      scan_q <= scan_q + CW'(1);
    end
  end

  // Reference column, held in a register; it may fall outside the coordinate range.
  logic signed [XW-1:0] xref_q;
  logic signed [XW-1:0] ext_s;
  logic signed [XW-1:0] shift_s;

  assign ext_s   = $signed({2'b00, ext_x_q});
  assign shift_s = $signed({{(XW - pcpf_pkg::ShiftW){1'b0}}, shift_q});

  always_ff @(posedge clk_i) begin
    xref_q <= dir_q ? (ext_s - shift_s) : (ext_s + shift_s);
  end

  // Scan stage one: data from the store.
  logic                 v1_q;
  logic                 first1_q;
  logic [CoordBits-1:0] e_x;
  logic [CoordBits-1:0] e_y;
  logic                 inner;
  logic signed [XW-1:0] diff;
  logic signed [XW-1:0] diff_abs;
  logic [PW-1:0]        prod;

  assign e_x      = rd_q[CoordBits-1:0];
  assign e_y      = rd_q[EW-1:CoordBits];
  assign inner    = dir_q ? (e_x < ext_x_q) : (e_x > ext_x_q);
  assign diff     = $signed({2'b00, e_x}) - xref_q;
  assign diff_abs = (diff < 0) ? -diff : diff;
  assign prod     = PW'(e_y) * PW'(count_q);

  // Scan stage two: product and distance registered before the compare.
  logic                 v2_q;
  logic                 s2_cand_q;
  logic [PW-1:0]        s2_prod_q;
  logic [DW-1:0]        s2_dist_q;
  logic [CoordBits-1:0] s2_x_q;
  logic [CoordBits-1:0] s2_y_q;
  logic [CoordBits-1:0] p0_x_q;
  logic [CoordBits-1:0] p0_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      first1_q <= (scan_q == '0);
    end
    if (v1_q) begin
      s2_cand_q <= inner;
      s2_prod_q <= prod;
      s2_dist_q <= diff_abs[DW-1:0];
      s2_x_q    <= e_x;
      s2_y_q    <= e_y;
      if (first1_q) begin
        p0_x_q <= e_x;
        p0_y_q <= e_y;
      end
    end
  end

  // Scan stage three: keep the nearest qualifying point, the first one on ties.
  logic                 found_q;
  logic [DW-1:0]        best_q;
  logic [CoordBits-1:0] side_x_q;
  logic [CoordBits-1:0] side_y_q;
  logic                 qual;
  logic                 take;

  assign qual = v2_q && s2_cand_q && (s2_prod_q < PW'(sum_q));
  assign take = qual && (!found_q || (s2_dist_q < best_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      best_q  <= '1;
    end else if (cmd_i.commit) begin
      found_q <= 1'b0;
      best_q  <= '1;
    end else if (take) begin
      found_q <= 1'b1;
      best_q  <= s2_dist_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      side_x_q <= s2_x_q;
      side_y_q <= s2_y_q;
    end
  end

  // Result register.
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      top_x_o      <= ext_x_q;
      top_y_o      <= top_y_q;
      side_x_o     <= found_q ? side_x_q : p0_x_q;
      side_y_o     <= found_q ? side_y_q : p0_y_q;
      side_found_o <= found_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign sts_o.issue_done = (scan_q == count_q);
  assign sts_o.pipe_busy  = v1_q || v2_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

endmodule

FILE: rtl/core/profile_corner_point_finder.sv
// Top level of the profile corner point finder: stream ports, controller and datapath.
//
// Contour points arrive one per cycle on the slave stream while the block is in its load phase,
// the last point flagged by tlast. After the last point the block stops taking points and
// scans the point store, one stored point per cycle through a three-stage pipeline (store
// read, product and distance, compare) through the single read port of the point store. The
// result is written once the pipeline has drained and the output register is free, and the
// next contour may then load. The result waits in an output register, so a new contour loads
// while the previous result is still pending. Points beyond MaxPoints are dropped. The
// configuration port is always ready and should only be written while no contour is in
// progress.
module profile_corner_point_finder #(
  parameter int MaxPoints = pcpf_pkg::DefMaxPoints,
  parameter int CoordBits = pcpf_pkg::DefCoordBits,
  localparam int InDW  = ((2 * CoordBits + 7) / 8) * 8,
  localparam int OutDW = ((4 * CoordBits + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pcpf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pcpf_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [InDW-1:0]               s_axis_tdata,   // point_x, point_y
  input  logic                          s_axis_tlast,   // last_point
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [OutDW-1:0]              m_axis_tdata,   // top_x, top_y, side_x, side_y
  output logic                          m_axis_tuser    // side_found
);

  pcpf_pkg::pcpf_cmd_t  cmd;
  pcpf_pkg::pcpf_sts_t  sts;
  logic [CoordBits-1:0] top_x;
  logic [CoordBits-1:0] top_y;
  logic [CoordBits-1:0] side_x;
  logic [CoordBits-1:0] side_y;

  assign cfg_ready_o = 1'b1;

  pcpf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pcpf_datapath #(
    .MaxPoints (MaxPoints),
    .CoordBits (CoordBits)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_x_i       (s_axis_tdata[CoordBits-1:0]),
    .in_y_i       (s_axis_tdata[2*CoordBits-1:CoordBits]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .top_x_o      (top_x),
    .top_y_o      (top_y),
    .side_x_o     (side_x),
    .side_y_o     (side_y),
    .side_found_o (m_axis_tuser)
  );

  assign m_axis_tdata = OutDW'({side_y, side_x, top_y, top_x});

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the profile corner point finder: random contours against a model.
`timescale 1ns / 1ps

module testbench;

  localparam int MaxPoints  = pcpf_pkg::DefMaxPoints;
  localparam int CoordBits  = pcpf_pkg::DefCoordBits;
  localparam int InDW       = ((2 * CoordBits + 7) / 8) * 8;
  localparam int OutDW      = ((4 * CoordBits + 7) / 8) * 8;
  localparam int StallLimit = 5000;

  // An index that names no register; writes to it must change nothing.
  localparam logic [pcpf_pkg::CfgIdxW-1:0] CfgIdxUnused = 8'hFF;

  typedef logic [CoordBits-1:0] coord_t;

  typedef struct packed {
    coord_t top_x;
    coord_t top_y;
    coord_t side_x;
    coord_t side_y;
    logic   found;
  } corner_t;

  // Tracks the contour being loaded and holds the corner results still owed by the block.
  class corner_checker;
    bit          right_side;
    int          shift;
    logic [23:0] contour [MaxPoints];
    int          count;
    int          extreme;
    int          top_idx;
    int          row_total;
    int          errors;
    corner_t     pending [$];

    function new();
      right_side = 1'b0;
      shift      = pcpf_pkg::ShiftReset;
      errors     = 0;
      clear();
    endfunction

    function void clear();
      count     = 0;
      extreme   = 0;
      top_idx   = 0;
      row_total = 0;
    endfunction

    function void set_register(logic [pcpf_pkg::CfgIdxW-1:0] idx,
                               logic [pcpf_pkg::CfgDataW-1:0] data);
      case (idx)
        pcpf_pkg::CfgIdxDirection: right_side = data[0];
        pcpf_pkg::CfgIdxShift:     shift = data;
        default: ;
      endcase
    endfunction

    function void note_point(coord_t x, coord_t y, bit last);
      bit      better;
      bit      found;
      bit      inner;
      int      ref_col;
      int      gap;
      int      best;
      int      side_idx;
      int      ex;
      int      ey;
      corner_t res;
      if (count < MaxPoints) begin
        better = (count == 0) || (right_side ? (x > extreme) : (x < extreme));
        contour[count] = {y, x};
        if (better) begin
          extreme = x;
          top_idx = count;
        end
        row_total += y;
        count++;
      end
      if (!last) return;
      // The reference column may fall outside the coordinate range; it is kept signed.
      ref_col  = right_side ? extreme - shift : extreme + shift;
      found    = 1'b0;
      best     = 0;
      side_idx = 0;
      for (int i = 0; i < count; i++) begin
        ex    = contour[i][CoordBits-1:0];
        ey    = contour[i][2*CoordBits-1:CoordBits];
        inner = right_side ? (ex < extreme) : (ex > extreme);
        if (inner && (ey * count < row_total)) begin
          gap = (ex < ref_col) ? ref_col - ex : ex - ref_col;
          if (!found || gap < best) begin
            best     = gap;
            side_idx = i;
            found    = 1'b1;
          end
        end
      end
      res.top_x  = contour[top_idx][CoordBits-1:0];
      res.top_y  = contour[top_idx][2*CoordBits-1:CoordBits];
      res.side_x = contour[side_idx][CoordBits-1:0];
      res.side_y = contour[side_idx][2*CoordBits-1:CoordBits];
      res.found  = found;
      pending.insert(pending.size(), res);
      clear();
    endfunction

    function void check_result(corner_t got);
      corner_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result top=(%0d,%0d) side=(%0d,%0d) found=%0b", $time,
                 got.top_x, got.top_y, got.side_x, got.side_y, got.found);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $display("%0t: mismatch, expected top=(%0d,%0d) side=(%0d,%0d) found=%0b", $time,
                 want.top_x, want.top_y, want.side_x, want.side_y, want.found);
        $display("%0t:           actual top=(%0d,%0d) side=(%0d,%0d) found=%0b", $time,
                 got.top_x, got.top_y, got.side_x, got.side_y, got.found);
        errors++;
      end
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [pcpf_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [pcpf_pkg::CfgDataW-1:0] cfg_data_i;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [InDW-1:0]               s_axis_tdata;   // point_x, point_y
  logic                          s_axis_tlast;   // last_point
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [OutDW-1:0]              m_axis_tdata;   // top_x, top_y, side_x, side_y
  logic                          m_axis_tuser;   // side_found

  corner_checker board;
  int            src_idle_pct;
  int            sink_idle_pct;
  int            n_sent;
  int            quiet_cycles = 0;

  profile_corner_point_finder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk_i) begin
    corner_t got;
    if (m_axis_tvalid && m_axis_tready) begin
      got.top_x  = m_axis_tdata[CoordBits-1:0];
      got.top_y  = m_axis_tdata[2*CoordBits-1:CoordBits];
      got.side_x = m_axis_tdata[3*CoordBits-1:2*CoordBits];
      got.side_y = m_axis_tdata[4*CoordBits-1:3*CoordBits];
      got.found  = m_axis_tuser;
      board.check_result(got);
    end
  end

  // Ends the run if the block stops moving requests on every channel.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= StallLimit) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_point(input coord_t x, input coord_t y, input bit last);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {y, x};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_point(x, y, last);
    n_sent++;
  endtask

  task automatic send_random_contour(input int len);
    int bx;
    int xspread;
    int by;
    int yspread;
    case ($urandom_range(3))
      0: begin
        bx = 0;
        xspread = 4095;
      end
      1: begin
        bx = 0;
        xspread = 300;
      end
      2: begin
        bx = 3795;
        xspread = 300;
      end
      default: begin
        bx = $urandom_range(4031);
        xspread = 64;
      end
    endcase
    if ($urandom_range(1)) begin
      by = 0;
      yspread = 4095;
    end else begin
      by = $urandom_range(3839);
      yspread = 256;
    end
    for (int i = 0; i < len; i++) begin
      send_point(coord_t'(bx + $urandom_range(xspread)), coord_t'(by + $urandom_range(yspread)),
                 i == len - 1);
    end
  endtask

  task automatic write_register(input logic [pcpf_pkg::CfgIdxW-1:0] idx,
                                input logic [pcpf_pkg::CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_register(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Withdraws the point request, waits for every owed result, then waits further so the scan
  // is surely finished.
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    int target;
    board         = new();
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    n_sent        = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int s = 0; s < 6; s++) begin
      case (s / 2)
        0: begin
          src_idle_pct  = 37;
          sink_idle_pct = 63;
        end
        1: begin
          src_idle_pct  = 63;
          sink_idle_pct = 37;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      if (s > 0) begin
        wait_drained();
        case (s)
          1: begin
            write_register(pcpf_pkg::CfgIdxDirection, 8'h01);
            write_register(pcpf_pkg::CfgIdxShift, 8'd0);
          end
          2: begin
            write_register(pcpf_pkg::CfgIdxDirection, 8'hFE);
            write_register(pcpf_pkg::CfgIdxShift, 8'd255);
          end
          3: begin
            write_register(pcpf_pkg::CfgIdxDirection, 8'hFF);
            write_register(CfgIdxUnused, 8'($urandom_range(255)));
          end
          4: begin
            write_register(pcpf_pkg::CfgIdxDirection, 8'h00);
            write_register(pcpf_pkg::CfgIdxShift, 8'd0);
          end
          default: begin
            write_register(pcpf_pkg::CfgIdxDirection, 8'h01);
            write_register(pcpf_pkg::CfgIdxShift, 8'($urandom_range(1, 254)));
          end
        endcase
      end

      if (s == 0) begin
        // Single-point contours at both corners of the coordinate range.
        send_point(12'd0, 12'd0, 1'b1);
        send_point(12'd4095, 12'd4095, 1'b1);
        // Tied extremes and two candidates at the same distance; the first wins each tie.
        send_point(12'd100, 12'd4000, 1'b0);
        send_point(12'd50, 12'd10, 1'b0);
        send_point(12'd50, 12'd20, 1'b0);
        send_point(12'd70, 12'd5, 1'b0);
        send_point(12'd60, 12'd6, 1'b0);
        send_point(12'd80, 12'd7, 1'b0);
        send_point(12'd50, 12'd30, 1'b1);
        // Every row sits exactly on the mean, so nothing qualifies.
        send_point(12'd10, 12'd2, 1'b0);
        send_point(12'd20, 12'd2, 1'b0);
        send_point(12'd30, 12'd2, 1'b1);
        // The reference column lies beyond the top of the coordinate range.
        send_point(12'd4095, 12'd0, 1'b0);
        send_point(12'd4090, 12'd100, 1'b0);
        send_point(12'd4093, 12'd1, 1'b1);
        // Alternating bit patterns in both fields.
        send_point(12'hAAA, 12'h555, 1'b0);
        send_point(12'h555, 12'hAAA, 1'b1);
      end

      target = n_sent + 86;
      while (n_sent < target) begin
        send_random_contour(($urandom_range(7) == 0) ? $urandom_range(13, 48)
                                                      : $urandom_range(1, 12));
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
